[hw/rtl/tensor_permute_address_gen_defines.svh]
`ifndef TENSOR_PERMUTE_ADDRESS_GEN_DEFINES_SVH
`define TENSOR_PERMUTE_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TPAG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpag check failed");

// Next-cycle implication, checked outside reset
`define TPAG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpag check failed");

`endif

[hw/rtl/tpag_pkg.sv]
`timescale 1ns / 1ps
package tpag_pkg;

    localparam int DEF_MAX_RANK   = 6;
    localparam int DEF_INDEX_BITS = 24;
    localparam int DEF_SIZE_BITS  = 13;

    // field widths fixed by the register map
    localparam int RANK_REG_BITS   = 3;
    localparam int PERM_FIELD_BITS = 3;
    localparam int CFG_INDEX_BITS  = 3;

    // restoring divide steps per pipeline stage
    localparam int DIV_STEP = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RANK  = 3'd0,
        REG_SIZE0 = 3'd1,
        REG_SIZE1 = 3'd2,
        REG_SIZE2 = 3'd3,
        REG_SIZE3 = 3'd4,
        REG_SIZE4 = 3'd5,
        REG_SIZE5 = 3'd6,
        REG_PERM  = 3'd7
    } tpag_reg_t;

    typedef struct packed {
        logic busy;
        logic cfg_ok;
    } tpag_status_t;

    // identity permutation over n dimensions, 3 bits per entry
    function automatic logic [8*PERM_FIELD_BITS-1:0] identity_perm(int n);
        logic [8*PERM_FIELD_BITS-1:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < n) begin
                r[PERM_FIELD_BITS*k +: PERM_FIELD_BITS] = PERM_FIELD_BITS'(k);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/tpag_cfg.sv]
`timescale 1ns / 1ps
module tpag_cfg
    import tpag_pkg::*;
#(
    parameter int MAX_RANK   = DEF_MAX_RANK,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS,
    localparam int CFG_DATA_W = (3*MAX_RANK > SIZE_BITS) ? 3*MAX_RANK : SIZE_BITS,
    localparam int S_W        = INDEX_BITS + 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    output tpag_status_t              status,
    output logic [S_W-1:0]            count,
    output logic [SIZE_BITS-1:0]      div_size [MAX_RANK],
    output logic [INDEX_BITS-1:0]     mul_stride [MAX_RANK]
);

    localparam int PW     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RANK_W = $clog2(MAX_RANK + 1);
    localparam int PERM_W = PERM_FIELD_BITS * MAX_RANK;
    localparam logic [PERM_W-1:0] PERM_RESET = PERM_W'(identity_perm(MAX_RANK));
    localparam logic [S_W-1:0] LIMIT = S_W'(1) << INDEX_BITS;

    logic [RANK_REG_BITS-1:0] rank_reg;
    logic [SIZE_BITS-1:0]     size_reg [MAX_RANK];
    logic [PERM_W-1:0]        perm_reg;

    logic                     seq_active_reg;
    logic                     settle_reg;
    logic [PW-1:0]            step_reg;
    logic [S_W-1:0]           acc_reg;
    logic [S_W-1:0]           acc_next;
    logic [INDEX_BITS-1:0]    in_stride_reg [MAX_RANK];
    logic [S_W-1:0]           count_reg;
    logic                     ok_reg;
    logic [SIZE_BITS-1:0]     div_reg [MAX_RANK];
    logic [INDEX_BITS-1:0]    mstride_reg [MAX_RANK];

    logic [3:0]               rank4;
    logic [RANK_W-1:0]        rank_eff;
    logic [PW-1:0]            sel [MAX_RANK];
    logic                     perm_ok;
    logic [CFG_INDEX_BITS-1:0] wr_dim;
    logic [S_W+SIZE_BITS-1:0] prod;
    logic                     step_used;

    // clamp rank to 1..MAX_RANK
    always_comb begin
        rank4 = {1'b0, rank_reg};
        if (rank4 == 4'd0) begin
            rank4 = 4'd1;
        end else if (rank4 > 4'(MAX_RANK)) begin
            rank4 = 4'(MAX_RANK);
        end
        rank_eff = RANK_W'(rank4);
    end

    // decode permutation; an entry that points beyond the rank clears perm_ok and selects dimension 0
    always_comb begin
        perm_ok = 1'b1;
        for (int k = 0; k < MAX_RANK; k++) begin
            sel[k] = perm_reg[PERM_FIELD_BITS*k +: PW];
            if ((4'(k) < rank4) &&
                ({1'b0, perm_reg[PERM_FIELD_BITS*k +: PERM_FIELD_BITS]} >= rank4)) begin
                perm_ok = 1'b0;
                sel[k]  = '0;
            end
        end
    end

    // register writes
    assign wr_dim = cfg_addr - CFG_INDEX_BITS'(REG_SIZE0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_REG_BITS'(1);
            perm_reg <= PERM_RESET;
            for (int k = 0; k < MAX_RANK; k++) begin
                size_reg[k] <= SIZE_BITS'(1);
            end
        end else if (cfg_we) begin
            case (tpag_reg_t'(cfg_addr))
                REG_RANK: rank_reg <= cfg_wdata[RANK_REG_BITS-1:0];
                REG_PERM: perm_reg <= cfg_wdata[PERM_W-1:0];
                default: begin
                    if ((cfg_addr inside {[REG_SIZE0:REG_SIZE5]}) &&
                        (4'(wr_dim) < 4'(MAX_RANK))) begin
                        size_reg[wr_dim[PW-1:0]] <= cfg_wdata[SIZE_BITS-1:0];
                    end
                end
            endcase
        end
    end

    // one capped stride product per sequencer step
    assign step_used = 4'(step_reg) < rank4;
    always_comb begin
        prod = {{SIZE_BITS{1'b0}}, acc_reg} * {{S_W{1'b0}}, size_reg[step_reg]};
        if (prod > (S_W+SIZE_BITS)'(LIMIT)) begin
            acc_next = LIMIT + S_W'(1);
        end else begin
            acc_next = prod[S_W-1:0];
        end
    end

    // walk dimensions innermost first after reset or a write
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            seq_active_reg <= 1'b1;
            settle_reg     <= 1'b0;
            step_reg       <= PW'(MAX_RANK - 1);
            acc_reg        <= S_W'(1);
        end else if (seq_active_reg) begin
            if (step_used) begin
                in_stride_reg[step_reg] <= acc_reg[INDEX_BITS-1:0];
                acc_reg <= acc_next;
            end
            if (step_reg == '0) begin
                seq_active_reg <= 1'b0;
                settle_reg     <= 1'b1;
                count_reg      <= step_used ? acc_next : acc_reg;
            end else begin
                step_reg <= step_reg - PW'(1);
            end
        end else begin
            settle_reg <= 1'b0;
        end
    end

    // per-dimension divisor and stride, unused dimensions neutral
    always_ff @(posedge aclk) begin
        ok_reg <= perm_ok && (count_reg <= LIMIT);
        for (int k = 0; k < MAX_RANK; k++) begin
            if (4'(k) < rank4) begin
                div_reg[k]     <= size_reg[sel[k]];
                mstride_reg[k] <= in_stride_reg[sel[k]];
            end else begin
                div_reg[k]     <= SIZE_BITS'(1);
                mstride_reg[k] <= '0;
            end
        end
    end

    assign status.busy   = seq_active_reg || settle_reg;
    assign status.cfg_ok = ok_reg && (rank_eff != '0);
    assign count         = count_reg;
    assign div_size      = div_reg;
    assign mul_stride    = mstride_reg;

endmodule

[hw/rtl/tpag_div_stage.sv]
`timescale 1ns / 1ps
module tpag_div_stage #(
    parameter int MAX_RANK   = 6,
    parameter int INDEX_BITS = 24,
    parameter int SIZE_BITS  = 13,
    parameter int DIM        = 0,
    parameter int HI         = 23,
    parameter int NB         = 4,
    parameter bit FIRST      = 1'b0,
    parameter bit LAST       = 1'b0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [INDEX_BITS-1:0]           in_q,
    input  logic [SIZE_BITS-1:0]            in_r,
    input  logic [MAX_RANK*SIZE_BITS-1:0]   in_coord,
    input  logic                            in_ok,
    input  logic [SIZE_BITS-1:0]            divisor,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [INDEX_BITS-1:0]           out_q,
    output logic [SIZE_BITS-1:0]            out_r,
    output logic [MAX_RANK*SIZE_BITS-1:0]   out_coord,
    output logic                            out_ok
);

    logic                          v_reg;
    logic [INDEX_BITS-1:0]         q_reg, q_next;
    logic [SIZE_BITS-1:0]          r_reg, r_next;
    logic [MAX_RANK*SIZE_BITS-1:0] c_reg, c_next;
    logic                          ok_reg;
    logic [SIZE_BITS:0]            t;

    // restoring long division over NB quotient bits, MSB first
    always_comb begin
        r_next = FIRST ? '0 : in_r;
        q_next = in_q;
        c_next = in_coord;
        t      = '0;
        for (int j = 0; j < NB; j++) begin
            t = {r_next, q_next[HI-j]};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
                q_next[HI-j] = 1'b1;
            end else begin
                q_next[HI-j] = 1'b0;
            end
            r_next = t[SIZE_BITS-1:0];
        end
        if (LAST) begin
            c_next[DIM*SIZE_BITS +: SIZE_BITS] = r_next;
        end
    end

    // advance when empty or downstream takes
    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            q_reg  <= q_next;
            r_reg  <= r_next;
            c_reg  <= c_next;
            ok_reg <= in_ok;
        end
    end

    assign out_valid = v_reg;
    assign out_q     = q_reg;
    assign out_r     = r_reg;
    assign out_coord = c_reg;
    assign out_ok    = ok_reg;

endmodule

[hw/rtl/tpag_acc_stage.sv]
`timescale 1ns / 1ps
module tpag_acc_stage #(
    parameter int MAX_RANK   = 6,
    parameter int INDEX_BITS = 24,
    parameter int SIZE_BITS  = 13,
    parameter int DIM        = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [INDEX_BITS-1:0]           in_acc,
    input  logic [MAX_RANK*SIZE_BITS-1:0]   in_coord,
    input  logic                            in_ok,
    input  logic [INDEX_BITS-1:0]           stride,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [INDEX_BITS-1:0]           out_acc,
    output logic [MAX_RANK*SIZE_BITS-1:0]   out_coord,
    output logic                            out_ok
);

    logic                            v_reg;
    logic [INDEX_BITS-1:0]           acc_reg, acc_next;
    logic [MAX_RANK*SIZE_BITS-1:0]   c_reg;
    logic                            ok_reg;
    logic [INDEX_BITS+SIZE_BITS-1:0] prod;

    // add one coordinate times its source stride, wrap to the index width
    assign prod     = {{INDEX_BITS{1'b0}}, in_coord[DIM*SIZE_BITS +: SIZE_BITS]}
                    * {{SIZE_BITS{1'b0}}, stride};
    assign acc_next = in_acc + prod[INDEX_BITS-1:0];

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            acc_reg <= acc_next;
            c_reg   <= in_coord;
            ok_reg  <= in_ok;
        end
    end

    assign out_valid = v_reg;
    assign out_acc   = acc_reg;
    assign out_coord = c_reg;
    assign out_ok    = ok_reg;

endmodule

[hw/rtl/tensor_permute_address_gen.sv]
`timescale 1ns / 1ps
// Permute address generator: maps a linear index of the permuted output tensor
// to the linear offset of the matching input element.
// Input channel s_valid/s_ready carries s_out_index; result channel
// m_valid/m_ready carries m_source_offset and m_offset_valid (offset is zero
// when the flag is low).
// Configuration: cfg_we/cfg_addr/cfg_wdata write rank, six sizes and the
// permutation. After reset and after each write a sequencer walks the
// dimensions to form the strides; s_ready stays low until it and its settle step are done.
// Throughput: one item per cycle while m_ready is high and no stride rebuild
// is in progress. Pipeline: MAX_RANK * ceil(INDEX_BITS / 4) divide stages plus
// MAX_RANK multiply-add stages; the divide chain takes 4 quotient bits per stage.
// Every stage has its own valid bit and fills bubbles, so when m_ready is low
// the result holds and s_ready stays high until the pipeline is full.
// Reset (aresetn low, synchronous) empties the pipeline and restores rank 1,
// sizes 1 and the identity permutation.
module tensor_permute_address_gen
    import tpag_pkg::*;
#(
    parameter int MAX_RANK   = DEF_MAX_RANK,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS,
    localparam int CFG_DATA_W = (3*MAX_RANK > SIZE_BITS) ? 3*MAX_RANK : SIZE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [INDEX_BITS-1:0]     s_out_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [INDEX_BITS-1:0]     m_source_offset,
    output logic                      m_offset_valid
);

`include "tensor_permute_address_gen_defines.svh"

    localparam int S_W  = INDEX_BITS + 2;
    localparam int NCH  = (INDEX_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NDIV = MAX_RANK * NCH;
    localparam int CW   = MAX_RANK * SIZE_BITS;

    tpag_status_t          status;
    logic [S_W-1:0]        count;
    logic [SIZE_BITS-1:0]  div_size [MAX_RANK];
    logic [INDEX_BITS-1:0] mul_stride [MAX_RANK];

    logic                  div_v   [NDIV+1];
    logic                  div_rdy [NDIV+1];
    logic [INDEX_BITS-1:0] div_q   [NDIV+1];
    logic [SIZE_BITS-1:0]  div_r   [NDIV+1];
    logic [CW-1:0]         div_c   [NDIV+1];
    logic                  div_ok  [NDIV+1];

    logic                  acc_v   [MAX_RANK+1];
    logic                  acc_rdy [MAX_RANK+1];
    logic [INDEX_BITS-1:0] acc_val [MAX_RANK+1];
    logic [CW-1:0]         acc_c   [MAX_RANK+1];
    logic                  acc_ok  [MAX_RANK+1];

    tpag_cfg #(
        .MAX_RANK  (MAX_RANK),
        .INDEX_BITS(INDEX_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .count     (count),
        .div_size  (div_size),
        .mul_stride(mul_stride)
    );

    // entry: check index against the element count, hold off while busy
    assign div_v[0]  = s_valid && !status.busy;
    assign s_ready   = div_rdy[0] && !status.busy;
    assign div_q[0]  = s_out_index;
    assign div_r[0]  = '0;
    assign div_c[0]  = '0;
    assign div_ok[0] = status.cfg_ok && ({2'b00, s_out_index} < count);

    // mixed-radix digit extraction, innermost dimension first
    for (genvar kp = 0; kp < MAX_RANK; kp++) begin : g_dim
        for (genvar c = 0; c < NCH; c++) begin : g_chunk
            localparam int N  = kp * NCH + c;
            localparam int HI = INDEX_BITS - 1 - c * DIV_STEP;
            localparam int NB = (HI + 1 < DIV_STEP) ? HI + 1 : DIV_STEP;
            tpag_div_stage #(
                .MAX_RANK  (MAX_RANK),
                .INDEX_BITS(INDEX_BITS),
                .SIZE_BITS (SIZE_BITS),
                .DIM       (MAX_RANK - 1 - kp),
                .HI        (HI),
                .NB        (NB),
                .FIRST     (c == 0),
                .LAST      (c == NCH - 1)
            ) u_div (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (div_v[N]),
                .in_ready (div_rdy[N]),
                .in_q     (div_q[N]),
                .in_r     (div_r[N]),
                .in_coord (div_c[N]),
                .in_ok    (div_ok[N]),
                .divisor  (div_size[MAX_RANK - 1 - kp]),
                .out_valid(div_v[N+1]),
                .out_ready(div_rdy[N+1]),
                .out_q    (div_q[N+1]),
                .out_r    (div_r[N+1]),
                .out_coord(div_c[N+1]),
                .out_ok   (div_ok[N+1])
            );
        end
    end

    // hand coordinates to the multiply-add chain
    assign acc_v[0]      = div_v[NDIV];
    assign div_rdy[NDIV] = acc_rdy[0];
    assign acc_val[0]    = '0;
    assign acc_c[0]      = div_c[NDIV];
    assign acc_ok[0]     = div_ok[NDIV];

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_acc
        tpag_acc_stage #(
            .MAX_RANK  (MAX_RANK),
            .INDEX_BITS(INDEX_BITS),
            .SIZE_BITS (SIZE_BITS),
            .DIM       (k)
        ) u_acc (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (acc_v[k]),
            .in_ready (acc_rdy[k]),
            .in_acc   (acc_val[k]),
            .in_coord (acc_c[k]),
            .in_ok    (acc_ok[k]),
            .stride   (mul_stride[k]),
            .out_valid(acc_v[k+1]),
            .out_ready(acc_rdy[k+1]),
            .out_acc  (acc_val[k+1]),
            .out_coord(acc_c[k+1]),
            .out_ok   (acc_ok[k+1])
        );
    end

    // drive results, zero the offset of an invalid item
    assign m_valid           = acc_v[MAX_RANK];
    assign acc_rdy[MAX_RANK] = m_ready;
    assign m_offset_valid    = acc_ok[MAX_RANK];
    assign m_source_offset   = acc_ok[MAX_RANK] ? acc_val[MAX_RANK] : '0;

    // a write blocks input on the next cycle while strides are rebuilt
    `TPAG_ASSERT_NEXT(a_cfg_blocks_input, aclk, aresetn, cfg_we, !s_ready)
    // a taken result frees room all the way back to the first stage
    `TPAG_ASSERT_NOW(a_ready_reaches_entry, aclk, aresetn, m_ready, div_rdy[0])

endmodule

[tb/sv/tensor_permute_address_gen_test.sv]
`timescale 1ns / 1ps
module tensor_permute_address_gen_test;
    import tpag_pkg::*;

    localparam int RANK_MAX = DEF_MAX_RANK;
    localparam int IDX_W    = DEF_INDEX_BITS;
    localparam int SZ_W     = DEF_SIZE_BITS;
    localparam int DATA_W   = (3*RANK_MAX > SZ_W) ? 3*RANK_MAX : SZ_W;
    localparam longint IDX_SPAN = longint'(1) << IDX_W;
    localparam int PIPE_DEPTH = 60;

    typedef struct {
        logic [IDX_W-1:0] offset;
        logic             valid;
    } addr_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_addr = '0;
    logic [DATA_W-1:0]         cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [IDX_W-1:0]          s_out_index = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [IDX_W-1:0]          m_source_offset;
    logic                      m_offset_valid;

    // shadow copy of the configuration, starting from the reset values
    logic [2:0]        rank_reg = 3'd1;
    logic [SZ_W-1:0]   size_reg [RANK_MAX] = '{default: SZ_W'(1)};
    logic [3*RANK_MAX-1:0] perm_reg = (3*RANK_MAX)'(identity_perm(RANK_MAX));

    logic [IDX_W-1:0]  index_queue [$];
    addr_result_t      offset_queue [$];
    int                mismatch_count = 0;
    bit                send_idle_en = 1'b1;
    bit                recv_idle_en = 1'b1;
    bit                in_taken = 1'b0;
    int                hold_off_cycles = 0;
    int                send_gap = 0;
    int                recv_gap = 0;

    tensor_permute_address_gen u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_out_index     (s_out_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_source_offset (m_source_offset),
        .m_offset_valid  (m_offset_valid)
    );

    always #1 aclk = ~aclk;

    function automatic longint cap_mul(longint a, longint b);
        longint p;
        p = a * b;
        return (p > IDX_SPAN) ? IDX_SPAN + 1 : p;
    endfunction

    // compute the source offset for one output index
    function automatic addr_result_t permute_offset(logic [IDX_W-1:0] out_idx);
        addr_result_t r;
        int rank;
        longint src_of [RANK_MAX];
        longint in_stride [RANK_MAX];
        longint out_size [RANK_MAX];
        longint out_stride [RANK_MAX];
        longint acc, total, coord, idx;
        bit ok;
        rank = rank_reg;
        ok = 1'b1;
        idx = out_idx;
        if (rank == 0) rank = 1;
        if (rank > RANK_MAX) rank = RANK_MAX;
        for (int k = 0; k < rank; k++) begin
            src_of[k] = perm_reg[3*k +: 3];
            if (src_of[k] >= rank) begin
                ok = 1'b0;
                src_of[k] = 0;
            end
        end
        acc = 1;
        for (int k = rank - 1; k >= 0; k--) begin
            in_stride[k] = acc;
            acc = cap_mul(acc, size_reg[k]);
        end
        total = acc;
        if (total > IDX_SPAN || idx >= total) ok = 1'b0;
        acc = 0;
        if (ok) begin
            for (int k = 0; k < rank; k++) out_size[k] = size_reg[src_of[k]];
            total = 1;
            for (int k = rank - 1; k >= 0; k--) begin
                out_stride[k] = total;
                total = cap_mul(total, out_size[k]);
            end
            for (int k = 0; k < rank; k++) begin
                coord = 0;
                if (out_stride[k] < IDX_SPAN && out_size[k] != 0)
                    coord = (idx / out_stride[k]) % out_size[k];
                acc += coord * in_stride[src_of[k]];
            end
        end
        r.offset = ok ? acc[IDX_W-1:0] : '0;
        r.valid = ok;
        return r;
    endfunction

    // record each accepted item and its expected result
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            offset_queue.push_back(permute_offset(s_out_index));
            void'(index_queue.pop_front());
        end
    end

    // driver: present queued items, idle in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold until accepted
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (index_queue.size() > 0) begin
            if (send_idle_en && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 12);
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_out_index <= index_queue[0];
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: stall in bursts, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        addr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (offset_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result offset=%0h valid=%0b",
                             m_source_offset, m_offset_valid);
            end else begin
                want = offset_queue.pop_front();
                if (want.offset !== m_source_offset || want.valid !== m_offset_valid) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected offset=%0h valid=%0b, got offset=%0h valid=%0b",
                                 want.offset, want.valid, m_source_offset, m_offset_valid);
                end
            end
        end
    end

    task automatic wait_drained();
        while (index_queue.size() > 0 || s_valid || offset_queue.size() > 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    task automatic write_reg(tpag_reg_t which, logic [DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= which;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (which)
            REG_RANK: rank_reg = value[2:0];
            REG_PERM: perm_reg = value[3*RANK_MAX-1:0];
            default:  size_reg[int'(which) - 1] = value[SZ_W-1:0];
        endcase
    endtask

    // program a full setting: rank, sizes and permutation
    task automatic apply_setting(int rank, int sz [RANK_MAX], logic [17:0] perm);
        write_reg(REG_RANK, DATA_W'(rank));
        write_reg(REG_SIZE0, DATA_W'(sz[0]));
        write_reg(REG_SIZE1, DATA_W'(sz[1]));
        write_reg(REG_SIZE2, DATA_W'(sz[2]));
        write_reg(REG_SIZE3, DATA_W'(sz[3]));
        write_reg(REG_SIZE4, DATA_W'(sz[4]));
        write_reg(REG_SIZE5, DATA_W'(sz[5]));
        write_reg(REG_PERM, DATA_W'(perm));
    endtask

    function automatic logic [17:0] random_perm(int rank);
        int order [RANK_MAX];
        int j, t;
        logic [17:0] p;
        for (int k = 0; k < RANK_MAX; k++) order[k] = k;
        for (int k = rank - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = order[k]; order[k] = order[j]; order[j] = t;
        end
        p = 18'($urandom);
        for (int k = 0; k < rank; k++) p[3*k +: 3] = 3'(order[k]);
        return p;
    endfunction

    function automatic longint element_count();
        longint c;
        int rank;
        rank = (rank_reg == 0) ? 1 : ((rank_reg > RANK_MAX) ? RANK_MAX : rank_reg);
        c = 1;
        for (int k = 0; k < rank; k++) c = cap_mul(c, size_reg[k]);
        return c;
    endfunction

    task automatic queue_random(int n);
        longint c;
        c = element_count();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8 && c <= IDX_SPAN)
                index_queue.push_back(IDX_W'($urandom_range(0, int'(c - 1))));
            else if ($urandom_range(0, 1))
                index_queue.push_back(IDX_W'($urandom));
            else
                index_queue.push_back(IDX_W'(c + $urandom_range(0, 3)));
        end
    endtask

    initial begin
        int sz [RANK_MAX];
        int rank;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset configuration, index extremes
        index_queue.push_back('0);
        index_queue.push_back(IDX_W'(1));
        index_queue.push_back('1);
        wait_drained();

        // directed: rank 6 small shape, reversed order, corners
        sz = '{2, 3, 4, 5, 2, 3};
        apply_setting(6, sz, {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5});
        index_queue.push_back('0);
        index_queue.push_back(IDX_W'(719));
        index_queue.push_back(IDX_W'(720));
        index_queue.push_back(IDX_W'(123));
        wait_drained();

        // directed: bad permutation entry, rank 0 and rank 7
        apply_setting(3, sz, {9'o0, 3'd0, 3'd1, 3'd5, 3'd0, 3'd0});
        index_queue.push_back(IDX_W'(5));
        wait_drained();
        apply_setting(0, sz, 18'o777770);
        index_queue.push_back(IDX_W'(1));
        index_queue.push_back('0);
        wait_drained();
        apply_setting(7, sz, 18'o012345);
        index_queue.push_back(IDX_W'(300));
        wait_drained();

        // directed: repeated entries, too many elements, max sizes
        sz = '{3, 7, 5, 0, 1, 1};
        apply_setting(3, sz, 18'o000011);
        index_queue.push_back(IDX_W'(20));
        index_queue.push_back(IDX_W'(104));
        wait_drained();
        sz = '{4096, 4096, 1, 1, 1, 1};
        apply_setting(2, sz, 18'o000010);
        index_queue.push_back('1);
        index_queue.push_back(IDX_W'(4097));
        wait_drained();
        sz = '{8191, 8191, 2, 1, 1, 1};
        apply_setting(3, sz, 18'o000000);
        index_queue.push_back(IDX_W'(77));
        wait_drained();
        sz = '{4096, 4097, 1, 1, 1, 1};
        apply_setting(2, sz, 18'o000001);
        index_queue.push_back(IDX_W'(9));
        wait_drained();
        sz = '{4096, 2, 2048, 1, 1, 1};
        apply_setting(3, sz, 18'o000000);
        index_queue.push_back(IDX_W'(16000000));
        wait_drained();

        // pressure: long receiver hold-off while the sender keeps offering
        hold_off_cycles = 200;
        sz = '{5, 6, 7, 8, 3, 2};
        apply_setting(6, sz, random_perm(6));
        queue_random(100);
        wait_drained();

        // random settings with random and out-of-range indexes
        for (int ph = 0; ph < 22; ph++) begin
            rank = $urandom_range(1, 6);
            for (int k = 0; k < RANK_MAX; k++) begin
                case ($urandom_range(0, 9))
                    0:       sz[k] = 1;
                    1:       sz[k] = 4096;
                    2:       sz[k] = $urandom_range(0, 8191);
                    default: sz[k] = $urandom_range(1, 12);
                endcase
            end
            if (ph % 7 == 3) rank = $urandom_range(0, 7);
            apply_setting(rank, sz,
                          ($urandom_range(0, 5) == 0) ? 18'($urandom) : random_perm(6));
            if (ph >= 19) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end
            queue_random(55);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("tensor_permute_address_gen regression: pass");
        else
            $display("tensor_permute_address_gen regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("tensor_permute_address_gen regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tpag_pkg.sv
hw/rtl/tpag_cfg.sv
hw/rtl/tpag_div_stage.sv
hw/rtl/tpag_acc_stage.sv
hw/rtl/tensor_permute_address_gen.sv
tb/sv/tensor_permute_address_gen_test.sv
